FILE: rtl/dmc_pkg.sv
// shared types, constants and helpers for the direct-mapped cache
`default_nettype none

package dmc_pkg;

  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int TAG_LSB  = 6;
  localparam int TAG_W    = ADDR_W - TAG_LSB;
  localparam int SET_LSB  = 2;
  localparam int SET_W    = TAG_LSB - SET_LSB;
  localparam int SETS     = 1 << SET_W;
  localparam int OFF_W    = SET_LSB;
  localparam int BYTES    = DATA_W / BYTE_W;
  localparam int STATUS_W = 3;

  // queue between front and back, power of two so pointers wrap naturally
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } dmc_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_INVALID  = 3'd2,
    ST_FILL     = 3'd3,
    ST_EVICT    = 3'd4
  } dmc_status_t;

  // decoded access as it travels through the queue
  typedef struct packed {
    dmc_op_t             op;
    logic [TAG_W-1:0]    tag;
    logic [SET_W-1:0]    set;
    logic [OFF_W-1:0]    off;
    logic [DATA_W-1:0]   fill_data;
  } dmc_req_t;

  // reverse the bit order inside each byte, byte positions unchanged
  function automatic logic [DATA_W-1:0] rev_bytes(input logic [DATA_W-1:0] w);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int k = 0; k < BYTES; k++) begin
      for (int i = 0; i < BYTE_W; i++) begin
        r[k*BYTE_W + i] = w[k*BYTE_W + BYTE_W - 1 - i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dmc_if.sv
// valid/ready channels for cache accesses and cache results
`default_nettype none

interface dmc_req_if
  import dmc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_value;

  modport source(output valid, opcode, address, write_value, input ready);
  modport sink(input valid, opcode, address, write_value, output ready);
endinterface

interface dmc_rsp_if
  import dmc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_byte;
  logic [TAG_W-1:0]    line_tag;
  logic [DATA_W-1:0]   line_data;

  modport source(output valid, status, read_byte, line_tag, line_data, input ready);
  modport sink(input valid, status, read_byte, line_tag, line_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/dmc_front.sv
// front end: accepts accesses, splits the address and prepares the fill word
`default_nettype none

module dmc_front
  import dmc_pkg::*;
(
  dmc_req_if.sink  req,
  output logic     push_valid,
  input  logic     push_ready,
  output dmc_req_t push_data
);

  always_comb begin
    push_valid          = req.valid;
    req.ready           = push_ready;
    push_data.op        = dmc_op_t'(req.opcode);
    push_data.tag       = req.address[ADDR_W-1:TAG_LSB];
    push_data.set       = req.address[TAG_LSB-1:SET_LSB];
    push_data.off       = req.address[OFF_W-1:0];
    // only writes use it, stored with each byte bit-reversed
    push_data.fill_data = rev_bytes(req.write_value);
  end

endmodule

`default_nettype wire

FILE: rtl/dmc_queue.sv
// short queue of decoded accesses between front and back
`default_nettype none

module dmc_queue
  import dmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  dmc_req_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output dmc_req_t pop_data
);

  dmc_req_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  always_comb begin
    push_ready = (count != QCNT_W'(QUEUE_DEPTH));
    pop_valid  = (count != '0);
    pop_data   = entries[rd_ptr];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dmc_back.sv
// back end: line lookup, fill on write and the result register
`default_nettype none

module dmc_back
  import dmc_pkg::*;
#(
  parameter int NUM_LINES = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  dmc_req_t pop_data,
  dmc_rsp_if.source rsp
);

  // set field is four bits, so lines past the sixteenth are never reached
  localparam int USED  = (NUM_LINES < SETS) ? NUM_LINES : SETS;
  localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;

  logic [USED-1:0]   line_valid;
  logic [TAG_W-1:0]  tag_store  [USED];
  logic [DATA_W-1:0] data_store [USED];

  logic [IDX_W-1:0]    idx;
  logic                hit_valid;
  logic [TAG_W-1:0]    old_tag;
  logic [DATA_W-1:0]   old_data;
  logic [BYTE_W-1:0]   old_byte;
  dmc_status_t         status_next;
  logic                pop;

  logic                rsp_valid;
  dmc_status_t         status;
  logic [BYTE_W-1:0]   read_byte;
  logic [TAG_W-1:0]    line_tag;
  logic [DATA_W-1:0]   line_data;

  always_comb begin
    // set modulo line count, folded into a constant lookup
    idx = '0;
    for (int s = 0; s < SETS; s++) begin
      if (pop_data.set == SET_W'(s)) begin
        idx = IDX_W'(s % USED);
      end
    end
    hit_valid = line_valid[idx];
    old_tag   = hit_valid ? tag_store[idx] : '0;
    old_data  = hit_valid ? data_store[idx] : '0;
    old_byte  = old_data[pop_data.off*BYTE_W +: BYTE_W];
    if (pop_data.op == OP_WRITE) begin
      status_next = hit_valid ? ST_EVICT : ST_FILL;
    end else if (!hit_valid) begin
      status_next = ST_INVALID;
    end else if (old_tag == pop_data.tag) begin
      status_next = ST_HIT;
    end else begin
      status_next = ST_MISMATCH;
    end
    pop_ready = !rsp_valid || rsp.ready;
    pop       = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (pop) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (pop && pop_data.op == OP_WRITE) begin
        line_valid[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status    <= status_next;
      read_byte <= old_byte;
      line_tag  <= old_tag;
      line_data <= old_data;
      if (pop_data.op == OP_WRITE) begin
        tag_store[idx]  <= pop_data.tag;
        data_store[idx] <= pop_data.fill_data;
      end
    end
  end

  always_comb begin
    rsp.valid     = rsp_valid;
    rsp.status    = status;
    rsp.read_byte = read_byte;
    rsp.line_tag  = line_tag;
    rsp.line_data = line_data;
  end

endmodule

`default_nettype wire

FILE: rtl/direct_mapped_cache_model.sv
// top level of the direct-mapped cache
`default_nettype none

// Direct-mapped cache of NUM_LINES lines of one four-byte block each. An
// access is a read lookup or a whole-line write with a 32-bit byte address
// (tag 31..6, set 5..2, offset 1..0); each gives exactly one result word with
// the status, the byte at the offset and the line's tag and data as they were
// before the access. Bytes are stored bit-reversed within each byte. The
// block sustains one access per clock unless results stall: the front
// decodes the address into a two-entry queue, and the back does the lookup
// and the line update together into an output register. An accepted access
// is queued, then registered at the output; a stalled result is absorbed by
// the queue before the input stops accepting. Only the first sixteen lines
// are reachable; below sixteen lines the set wraps around.

module direct_mapped_cache_model
  import dmc_pkg::*;
#(
  parameter int NUM_LINES = 16
) (
  input  logic      clk,
  input  logic      rst,
  dmc_req_if.sink   req,
  dmc_rsp_if.source rsp
);

  logic     push_valid;
  logic     push_ready;
  dmc_req_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  dmc_req_t pop_data;

  dmc_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dmc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dmc_back #(
    .NUM_LINES (NUM_LINES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/dmc_checker.sv
// port-level checks on the cache results, bound to the top level
`default_nettype none

module dmc_checker
  import dmc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [BYTE_W-1:0]   read_byte,
  input logic [TAG_W-1:0]    line_tag,
  input logic [DATA_W-1:0]   line_data
);

  // status codes above evict are never produced
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= ST_EVICT)
    else $error("result status out of range");

  // an invalid line reports nothing of its old contents
  a_empty_line_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_INVALID || status == ST_FILL)
      |-> line_tag == '0 && line_data == '0 && read_byte == '0)
    else $error("invalid line returned nonzero contents");

  // the byte always comes out of the reported line word
  a_byte_from_line: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> read_byte == line_data[7:0] || read_byte == line_data[15:8] ||
                  read_byte == line_data[23:16] || read_byte == line_data[31:24])
    else $error("read byte not found in line data");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(read_byte) && $stable(line_tag) && $stable(line_data))
    else $error("result word changed while stalled");

endmodule

bind direct_mapped_cache_model dmc_checker u_dmc_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .read_byte (rsp.read_byte),
  .line_tag  (rsp.line_tag),
  .line_data (rsp.line_data)
);

`default_nettype wire
